/* sv/pfc_pkg.sv */
// Shared types, constants and lookup functions of the Playfair digraph cipher core.
`default_nettype none
package pfc_pkg;

   localparam int GRID     = 5;
   localparam int CODE_W   = 5;
   localparam int POS_W    = 3;
   localparam int ROW_W    = GRID * CODE_W;
   localparam int CSR_AW   = 3;

   // Queue depths must be powers of two: the pointers wrap naturally.
   localparam int PQ_DEPTH = 4;
   localparam int PQ_AW    = $clog2(PQ_DEPTH);
   localparam int OQ_DEPTH = 2;
   localparam int OQ_AW    = $clog2(OQ_DEPTH);

   localparam logic [CODE_W-1:0] CODE_X = 5'd23;
   localparam logic [CODE_W-1:0] CODE_I = 5'd8;
   localparam logic [CODE_W-1:0] CODE_J = 5'd9;
   localparam logic [CODE_W-1:0] CODE_MAX = 5'd25;

   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [6:0] ASCII_A      = 7'h41;
   localparam logic [6:0] ASCII_Z      = 7'h5A;

   localparam logic [POS_W-1:0] STEP_ENC = 3'd1;
   localparam logic [POS_W-1:0] STEP_DEC = 3'd4;

   localparam logic [CSR_AW-1:0] REG_MODE = 3'd0;
   localparam logic [CSR_AW-1:0] REG_ROW0 = 3'd1;
   localparam logic [CSR_AW-1:0] REG_ROW4 = 3'd5;

   localparam logic MODE_ENCRYPT = 1'b0;

   typedef struct packed {
      logic [7:0] in_char;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       out_last;
   } rsp_type;

   typedef logic [GRID-1:0][ROW_W-1:0] matrix_type;

   typedef struct packed {
      logic [CODE_W-1:0] first;
      logic [CODE_W-1:0] second;
      logic              last;
   } pair_type;

   typedef struct packed {
      logic empty;
      logic full;
   } pq_status_type;

   typedef struct packed {
      logic [6:0] char0;
      logic [6:0] char1;
      logic       last;
   } opair_type;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
   } loc_type;

   // First match in row-major order wins; a missing code sits at row 0, column 0.
   function automatic loc_type locate(matrix_type m, logic [CODE_W-1:0] code);
      loc_type res;
      res = '0;
      for (int r = GRID - 1; r >= 0; r--) begin
         for (int c = GRID - 1; c >= 0; c--) begin
            if (m[r][c*CODE_W +: CODE_W] == code) begin
               res.row = POS_W'(r);
               res.col = POS_W'(c);
            end
         end
      end
      return res;
   endfunction

   function automatic logic [POS_W-1:0] add_mod5(logic [POS_W-1:0] x, logic [POS_W-1:0] step);
      logic [POS_W:0] s;
      s = {1'b0, x} + {1'b0, step};
      if (s >= (POS_W+1)'(GRID)) begin
         s = s - (POS_W+1)'(GRID);
      end
      return s[POS_W-1:0];
   endfunction

   function automatic logic [CODE_W-1:0] cell_at(matrix_type m, logic [POS_W-1:0] r,
                                                 logic [POS_W-1:0] c);
      return m[r][int'(c)*CODE_W +: CODE_W];
   endfunction

   function automatic logic [6:0] to_ascii(logic [CODE_W-1:0] code);
      return (code <= CODE_MAX) ? (ASCII_A + {2'b00, code}) : ASCII_Z;
   endfunction

endpackage
`default_nettype wire

/* sv/pfc_front.sv */
// Front end: letter filter, pending letter and digraph formation.
`default_nettype none
module pfc_front import pfc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          mode,
   input  wire logic          req_push,
   output logic               req_full,
   input  wire req_type       req_data,
   input  wire pq_status_type pq_status,
   output logic               pq_push,
   output pair_type           pq_data
);

   logic              pend_valid_ff, pend_valid_in;
   logic [CODE_W-1:0] pend_letter_ff, pend_letter_in;
   logic              spill_valid_ff, spill_valid_in;
   pair_type          spill_ff, spill_in;

   logic              accept;
   logic              is_letter;
   logic [CODE_W-1:0] code;
   logic [1:0]        npairs;
   pair_type          pair0, pair1;

   assign req_full = spill_valid_ff | pq_status.full;
   assign accept   = req_push & ~req_full;

   always_comb begin
      is_letter = 1'b1;
      code      = '0;
      if (req_data.in_char inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
         code = CODE_W'(req_data.in_char - CHAR_UPPER_A);
      end else if (req_data.in_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) begin
         code = CODE_W'(req_data.in_char - CHAR_LOWER_A);
      end else begin
         is_letter = 1'b0;
      end
      if (code == CODE_J) begin
         code = CODE_I;
      end
   end

   always_comb begin
      pend_valid_in  = pend_valid_ff;
      pend_letter_in = pend_letter_ff;
      npairs         = 2'd0;
      pair0          = '0;
      pair1          = '0;
      if (is_letter) begin
         if (!pend_valid_ff) begin
            pend_valid_in  = 1'b1;
            pend_letter_in = code;
         end else if (mode == MODE_ENCRYPT && pend_letter_ff == code) begin
            // split a doubled letter with X, keep the second one pending
            pair0          = '{first: pend_letter_ff, second: CODE_X, last: 1'b0};
            npairs         = 2'd1;
            pend_letter_in = code;
         end else begin
            pair0         = '{first: pend_letter_ff, second: code, last: req_data.in_last};
            npairs        = 2'd1;
            pend_valid_in = 1'b0;
         end
      end
      if (req_data.in_last) begin
         if (pend_valid_in) begin
            if (npairs == 2'd0) begin
               pair0 = '{first: pend_letter_in, second: CODE_X, last: 1'b1};
            end else begin
               pair1 = '{first: pend_letter_in, second: CODE_X, last: 1'b1};
            end
            npairs = npairs + 2'd1;
         end
         pend_valid_in  = 1'b0;
         pend_letter_in = '0;
      end
   end

   always_comb begin
      spill_valid_in = spill_valid_ff;
      spill_in       = spill_ff;
      pq_push        = 1'b0;
      pq_data        = spill_ff;
      if (spill_valid_ff) begin
         if (!pq_status.full) begin
            pq_push        = 1'b1;
            spill_valid_in = 1'b0;
         end
      end else if (accept && npairs != 2'd0) begin
         pq_push = 1'b1;
         pq_data = pair0;
         if (npairs == 2'd2) begin
            spill_valid_in = 1'b1;
            spill_in       = pair1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff  <= 1'b0;
         pend_letter_ff <= '0;
         spill_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            pend_valid_ff  <= pend_valid_in;
            pend_letter_ff <= pend_letter_in;
         end
         spill_valid_ff <= spill_valid_in;
      end
      spill_ff <= spill_in;
   end

   a_spill_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(spill_valid_ff) |-> $past(accept))
      else $error("spill raised without an accepted transaction");

endmodule
`default_nettype wire

/* sv/pfc_pair_fifo.sv */
// Short queue of digraphs between the front end and the lookup stage.
`default_nettype none
module pfc_pair_fifo import pfc_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire pair_type push_data,
   input  wire logic     pop,
   output pair_type      head,
   output pq_status_type status
);

   pair_type         mem_ff [PQ_DEPTH];
   logic [PQ_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PQ_AW:0]   count_ff, count_in;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == (PQ_AW+1)'(PQ_DEPTH));
   assign head         = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!status.full || pop))
      else $error("pair queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pair queue read while empty");

endmodule
`default_nettype wire

/* sv/pfc_back.sv */
// Back end: matrix lookup of one digraph per cycle while the result queue has room, and letter-by-letter result queue.
`default_nettype none
module pfc_back import pfc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          mode,
   input  wire matrix_type    matrix,
   input  wire pair_type      pq_head,
   input  wire pq_status_type pq_status,
   output logic               pq_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output rsp_type            rsp_data
);

   opair_type        oq_ff [OQ_DEPTH];
   logic [OQ_AW-1:0] oq_wr_ff, oq_rd_ff;
   logic [OQ_AW:0]   oq_count_ff, oq_count_in;
   logic             half_ff;

   loc_type          loc_a, loc_b;
   logic [POS_W-1:0] step;
   logic [CODE_W-1:0] code_a, code_b;
   opair_type        result;
   logic             fire;
   logic             take;
   logic             release_pair;

   always_comb begin
      loc_a = locate(matrix, pq_head.first);
      loc_b = locate(matrix, pq_head.second);
      step  = (mode == MODE_ENCRYPT) ? STEP_ENC : STEP_DEC;
      if (loc_a.row == loc_b.row) begin
         code_a = cell_at(matrix, loc_a.row, add_mod5(loc_a.col, step));
         code_b = cell_at(matrix, loc_b.row, add_mod5(loc_b.col, step));
      end else if (loc_a.col == loc_b.col) begin
         code_a = cell_at(matrix, add_mod5(loc_a.row, step), loc_a.col);
         code_b = cell_at(matrix, add_mod5(loc_b.row, step), loc_b.col);
      end else begin
         code_a = cell_at(matrix, loc_a.row, loc_b.col);
         code_b = cell_at(matrix, loc_b.row, loc_a.col);
      end
      result = '{char0: to_ascii(code_a), char1: to_ascii(code_b), last: pq_head.last};
   end

   assign fire         = !pq_status.empty && (oq_count_ff != (OQ_AW+1)'(OQ_DEPTH));
   assign pq_pop       = fire;
   assign rsp_empty    = (oq_count_ff == '0);
   assign take         = rsp_pop & ~rsp_empty;
   assign release_pair = take & half_ff;

   always_comb begin
      rsp_data.out_char = half_ff ? oq_ff[oq_rd_ff].char1 : oq_ff[oq_rd_ff].char0;
      rsp_data.out_last = half_ff & oq_ff[oq_rd_ff].last;
   end

   always_comb begin
      oq_count_in = oq_count_ff;
      if (fire && !release_pair) begin
         oq_count_in = oq_count_ff + 1'b1;
      end else if (release_pair && !fire) begin
         oq_count_in = oq_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff    <= '0;
         oq_rd_ff    <= '0;
         oq_count_ff <= '0;
         half_ff     <= 1'b0;
      end else begin
         if (fire) begin
            oq_wr_ff <= oq_wr_ff + 1'b1;
         end
         if (release_pair) begin
            oq_rd_ff <= oq_rd_ff + 1'b1;
         end
         // advance to the second letter, then drop the pair
         if (take) begin
            half_ff <= ~half_ff;
         end
         oq_count_ff <= oq_count_in;
      end
      if (fire) begin
         oq_ff[oq_wr_ff] <= result;
      end
   end

   a_half_needs_pair: assert property (@(posedge clock) disable iff (reset)
      half_ff |-> !rsp_empty)
      else $error("second letter selected with no pair queued");

endmodule
`default_nettype wire

/* sv/playfair_digraph_cipher_core.sv */
// Top level of the Playfair digraph cipher core: control registers and front/back wiring.
//
//   channel  ports                               transaction moves on
//   req      req_push, req_full, req_data        push & !full: one text byte
//   rsp      rsp_empty, rsp_pop, rsp_data        pop & !empty: one letter
//   csr      csr_valid, csr_ready, csr_index,    valid & ready: one register write
//            csr_data
//
// A text byte is taken each cycle that req_full is low; req_full is high while the pair
// queue is full, or while the second digraph of a byte that yields two waits to enter it.
// The lookup stage resolves one digraph per cycle while the result queue has room; the
// result side delivers one letter per cycle while rsp_pop is high, first letter then second.
// Reset clears the pending letter, both queues, the mode and the matrix rows.
// Either side may stall indefinitely.
`default_nettype none
module playfair_digraph_cipher_core import pfc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_push,
   output logic                   req_full,
   input  wire req_type           req_data,
   output logic                   rsp_empty,
   input  wire logic              rsp_pop,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [CSR_AW-1:0] csr_index,
   input  wire logic [ROW_W-1:0]  csr_data
);

   logic          mode_ff;
   matrix_type    matrix_ff;
   logic          csr_write;
   logic [CSR_AW-1:0] row_sel;

   logic          pq_push;
   logic          pq_pop;
   pair_type      pq_data;
   pair_type      pq_head;
   pq_status_type pq_status;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign row_sel   = csr_index - REG_ROW0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         matrix_ff <= '0;
      end else if (csr_write) begin
         if (csr_index == REG_MODE) begin
            mode_ff <= csr_data[0];
         end else if (csr_index inside {[REG_ROW0:REG_ROW4]}) begin
            matrix_ff[row_sel] <= csr_data;
         end
      end
   end

   pfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .pq_status (pq_status),
      .pq_push   (pq_push),
      .pq_data   (pq_data)
   );

   pfc_pair_fifo u_pair_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (pq_push),
      .push_data (pq_data),
      .pop       (pq_pop),
      .head      (pq_head),
      .status    (pq_status)
   );

   pfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .matrix    (matrix_ff),
      .pq_head   (pq_head),
      .pq_status (pq_status),
      .pq_pop    (pq_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

/* tb/sv/pfc_tb_pkg.sv */
// Scoreboard class that predicts and checks the letters of the Playfair digraph cipher core.
package pfc_tb_pkg;
   import pfc_pkg::*;

   class digraph_tracker;
      logic              mode;
      logic [ROW_W-1:0]  rows [GRID];
      logic              held_valid;
      logic [CODE_W-1:0] held_code;
      rsp_type           expected_letters [$];
      int                errors;
      int                bytes_seen;
      int                messages_seen;
      int                pads_seen;
      int                letters_checked;
      int                csr_writes;

      function new();
         mode = MODE_ENCRYPT;
         foreach (rows[r]) rows[r] = '0;
         held_valid = 1'b0;
         held_code = '0;
      endfunction

      function void write_reg(input logic [CSR_AW-1:0] idx, input logic [ROW_W-1:0] val);
         csr_writes++;
         if (idx == REG_MODE) begin
            mode = val[0];
         end else if (idx >= REG_ROW0 && idx <= REG_ROW4) begin
            rows[int'(idx - REG_ROW0)] = val;
         end
         // drop writes to indexes past the last row
      endfunction

      function logic [CODE_W-1:0] code_at(input int r, input int c);
         return rows[r][c*CODE_W +: CODE_W];
      endfunction

      // first hit in row-major order; a code that is missing sits at the top left
      function void find_code(input logic [CODE_W-1:0] code, output int row, output int col);
         bit found;
         found = 1'b0;
         row = 0;
         col = 0;
         for (int r = 0; r < GRID && !found; r++) begin
            for (int c = 0; c < GRID && !found; c++) begin
               if (code_at(r, c) == code) begin
                  row = r;
                  col = c;
                  found = 1'b1;
               end
            end
         end
      endfunction

      function logic [6:0] letter_of(input logic [CODE_W-1:0] code);
         return (code <= CODE_MAX) ? ASCII_A + 7'(code) : ASCII_Z;
      endfunction

      function void encode_digraph(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
                                   input logic last);
         int                ra, ca, rb, cb, shift;
         logic [CODE_W-1:0] oa, ob;
         shift = (mode == MODE_ENCRYPT) ? int'(STEP_ENC) : int'(STEP_DEC);
         find_code(a, ra, ca);
         find_code(b, rb, cb);
         if (ra == rb) begin
            oa = code_at(ra, (ca + shift) % GRID);
            ob = code_at(rb, (cb + shift) % GRID);
         end else if (ca == cb) begin
            oa = code_at((ra + shift) % GRID, ca);
            ob = code_at((rb + shift) % GRID, cb);
         end else begin
            oa = code_at(ra, cb);
            ob = code_at(rb, ca);
         end
         expected_letters.push_back(rsp_type'{out_char: letter_of(oa), out_last: 1'b0});
         expected_letters.push_back(rsp_type'{out_char: letter_of(ob), out_last: last});
      endfunction

      function void note_byte(input req_type item);
         logic [CODE_W-1:0] code;
         logic              letter;
         code = '0;
         letter = 1'b1;
         bytes_seen++;
         if (item.in_char >= CHAR_UPPER_A && item.in_char <= CHAR_UPPER_Z) begin
            code = CODE_W'(item.in_char - CHAR_UPPER_A);
         end else if (item.in_char >= CHAR_LOWER_A && item.in_char <= CHAR_LOWER_Z) begin
            code = CODE_W'(item.in_char - CHAR_LOWER_A);
         end else begin
            letter = 1'b0;
         end
         if (code == CODE_J) code = CODE_I;

         if (letter) begin
            if (!held_valid) begin
               held_valid = 1'b1;
               held_code = code;
            end else if (mode == MODE_ENCRYPT && held_code == code) begin
               // split the doubled letter, keep the second one waiting
               encode_digraph(held_code, CODE_X, 1'b0);
               pads_seen++;
            end else begin
               encode_digraph(held_code, code, item.in_last);
               held_valid = 1'b0;
            end
         end

         if (item.in_last) begin
            messages_seen++;
            if (held_valid) begin
               encode_digraph(held_code, CODE_X, 1'b1);
               pads_seen++;
            end
            held_valid = 1'b0;
            held_code = '0;
         end
      endfunction

      function void check_letter(input rsp_type got);
         rsp_type want;
         if (expected_letters.size() == 0) begin
            $error("unexpected letter: out_char %c (%0h), out_last %0b",
                   got.out_char, got.out_char, got.out_last);
            errors++;
            return;
         end
         want = expected_letters.pop_front();
         letters_checked++;
         if (got.out_char !== want.out_char) begin
            $error("out_char mismatch: expected %c (%0h), actual %c (%0h)",
                   want.out_char, want.out_char, got.out_char, got.out_char);
            errors++;
         end
         if (got.out_last !== want.out_last) begin
            $error("out_last mismatch: expected %0b, actual %0b", want.out_last, got.out_last);
            errors++;
         end
      endfunction

      function int outstanding();
         return expected_letters.size();
      endfunction

      function void close_out();
         if (expected_letters.size() != 0) begin
            $error("%0d expected letters never arrived", expected_letters.size());
            errors += expected_letters.size();
         end
      endfunction
   endclass

endpackage

/* tb/sv/tb_playfair_digraph_cipher_core.sv */
// Top-level testbench of the Playfair digraph cipher core: stimulus, handshakes and checks.
module tb_playfair_digraph_cipher_core;
   import pfc_pkg::*;
   import pfc_tb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT   = 2000;
   localparam int LONG_HOLD     = 400;
   localparam int SETTLE_CYCLES = 8;

   localparam logic              MODE_DECRYPT = ~MODE_ENCRYPT;
   localparam logic [CSR_AW-1:0] REG_SPARE_LO = REG_ROW4 + 3'd1;
   localparam logic [CSR_AW-1:0] REG_SPARE_HI = '1;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_push  = 1'b0;
   logic              req_full;
   req_type           req_data  = '0;
   logic              rsp_empty;
   logic              rsp_pop   = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [ROW_W-1:0]  csr_data  = '0;

   digraph_tracker    tracker;
   logic [ROW_W-1:0]  key_rows [GRID];
   bit                tx_gaps      = 1'b0;
   bit                rx_gaps      = 1'b0;
   bit                rsp_hold_req = 1'b0;
   int                quiet_cycles = 0;

   playfair_digraph_cipher_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Watch every transaction at the edge it completes on; values read here are pre-edge.
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (csr_valid && csr_ready) begin
            tracker.write_reg(csr_index, csr_data);
            quiet_cycles = 0;
         end
         if (req_push && !req_full) begin
            tracker.note_byte(req_data);
            quiet_cycles = 0;
         end
         if (rsp_pop && !rsp_empty) begin
            tracker.check_letter(rsp_data);
            quiet_cycles = 0;
         end
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // Letter receiver: random stalls, plus one long hold on request.
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold_req) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_hold_req = 1'b0;
         end else if (rx_gaps && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] ch, input logic last);
      if (tx_gaps && $urandom_range(0, 5) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_data <= req_type'{in_char: ch, in_last: last};
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stop sending, wait for every expected letter, then let the pipeline drain.
   task automatic settle();
      req_push <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_AW-1:0] idx, input logic [ROW_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_key(input logic mode_val);
      settle();
      write_csr(REG_MODE, ROW_W'(mode_val));
      for (int r = 0; r < GRID; r++) write_csr(REG_ROW0 + CSR_AW'(r), key_rows[r]);
   endtask

   // Alphabet without J, row-major, optionally shuffled.
   function automatic void fill_key(input bit shuffled);
      logic [CODE_W-1:0] codes [GRID*GRID];
      logic [CODE_W-1:0] swap;
      int                k, j;
      k = 0;
      for (int n = 0; n < GRID*GRID; n++) begin
         if (k == CODE_J) k++;
         codes[n] = CODE_W'(k);
         k++;
      end
      if (shuffled) begin
         for (int n = GRID*GRID - 1; n > 0; n--) begin
            j = $urandom_range(0, n);
            swap = codes[n];
            codes[n] = codes[j];
            codes[j] = swap;
         end
      end
      for (int n = 0; n < GRID*GRID; n++) begin
         key_rows[n / GRID][(n % GRID)*CODE_W +: CODE_W] = codes[n];
      end
   endfunction

   function automatic logic [7:0] random_text_byte(input logic [7:0] prev);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15) return prev ^ ($urandom_range(0, 1) ? 8'h20 : 8'h00);
      if (pick < 22) return $urandom_range(0, 1) ? "J" : "j";
      if (pick < 75) begin
         return ($urandom_range(0, 1) ? CHAR_UPPER_A : CHAR_LOWER_A) + 8'($urandom_range(0, 25));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   // Whole messages with random content; every byte sent counts toward the quota.
   task automatic stream_messages(input int quota);
      int         counted, span;
      logic [7:0] ch, prev;
      logic       fin, letter;
      counted = 0;
      prev = CHAR_UPPER_A;
      while (counted < quota) begin
         span = $urandom_range(1, 12);
         for (int i = 0; i < span; i++) begin
            fin = (i == span - 1);
            ch = random_text_byte(prev);
            letter = ((ch | 8'h20) >= CHAR_LOWER_A) && ((ch | 8'h20) <= CHAR_LOWER_Z);
            if (letter) prev = ch;
            counted++;
            send_byte(ch, fin);
         end
      end
   endtask

   initial begin
      tracker = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key: every cell holds A.
      tx_gaps = 1'b1;
      rx_gaps = 1'b1;
      send_byte("a", 1'b0);
      send_byte("Z", 1'b1);

      fill_key(1'b0);
      load_key(MODE_ENCRYPT);
      write_csr(REG_SPARE_LO, '1);
      write_csr(REG_SPARE_HI, ROW_W'($urandom));
      send_byte("A", 1'b0);      // same row
      send_byte("B", 1'b0);
      send_byte("e", 1'b0);      // same row, wraps to column 0
      send_byte("a", 1'b0);
      send_byte("V", 1'b0);      // same column, wraps to row 0
      send_byte("a", 1'b0);
      send_byte("M", 1'b0);      // rectangle
      send_byte("u", 1'b0);
      send_byte("j", 1'b0);      // J folds to I and doubles
      send_byte("I", 1'b0);
      send_byte("@", 1'b0);
      send_byte("q", 1'b0);
      send_byte("k", 1'b0);      // doubled letter on the final byte
      send_byte("K", 1'b1);
      send_byte("z", 1'b1);      // odd final letter
      send_byte(8'h00, 1'b1);    // final non-letter with nothing held
      send_byte("h", 1'b0);
      send_byte(8'hFF, 1'b1);    // final non-letter flushes the held letter
      send_byte("c", 1'b0);
      // switch to decrypt while C is held
      settle();
      write_csr(REG_MODE, ROW_W'(MODE_DECRYPT));
      send_byte("d", 1'b0);
      send_byte("e", 1'b0);      // doubled letter, no pad when decrypting
      send_byte("E", 1'b0);
      send_byte("w", 1'b1);      // odd final letter when decrypting

      fill_key(1'b1);
      load_key(MODE_ENCRYPT);
      stream_messages(50);

      load_key(MODE_DECRYPT);
      stream_messages(30);
      // hold the receiver while the sender keeps pushing
      tx_gaps = 1'b0;
      rsp_hold_req = 1'b1;
      stream_messages(40);
      tx_gaps = 1'b1;

      // duplicated, missing and out-of-range codes
      for (int n = 0; n < GRID*GRID; n++) begin
         key_rows[n / GRID][(n % GRID)*CODE_W +: CODE_W] = ($urandom_range(0, 3) == 0) ?
            CODE_W'($urandom_range(26, 31)) : CODE_W'($urandom_range(0, 25));
      end
      rx_gaps = 1'b0;
      load_key(MODE_ENCRYPT);
      stream_messages(50);

      foreach (key_rows[r]) key_rows[r] = '1;
      tx_gaps = 1'b0;
      rx_gaps = 1'b1;
      load_key(MODE_DECRYPT);
      stream_messages(30);

      fill_key(1'b1);
      rx_gaps = 1'b0;
      load_key(MODE_ENCRYPT);
      stream_messages(50);

      settle();
      tracker.close_out();
      $display("Covered %0d text bytes in %0d messages; %0d letters checked, %0d X pads.",
               tracker.bytes_seen, tracker.messages_seen, tracker.letters_checked,
               tracker.pads_seen);
      $display("Keys: reset, alphabetic, shuffled, malformed, all ones; both modes; %0d csr writes.",
               tracker.csr_writes);
      if (tracker.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/pfc_pkg.sv
sv/pfc_front.sv
sv/pfc_pair_fifo.sv
sv/pfc_back.sv
sv/playfair_digraph_cipher_core.sv
tb/sv/pfc_tb_pkg.sv
tb/sv/tb_playfair_digraph_cipher_core.sv
